// File: src/rwa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwa_pkg
// Shared sizes, controller state codes and command/status bundles for the
// running window average block.
// ----------------------------------------------------------------------------
package rwa_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 16;

    // Ring address, fill count and total widths follow from the window depth
    localparam int POS_BITS   = $clog2(WINDOW_MAX);
    localparam int FILL_BITS  = $clog2(2 * WINDOW_MAX);
    localparam int TOTAL_BITS = SAMPLE_BITS + POS_BITS;
    localparam int CNT_BITS   = $clog2(TOTAL_BITS + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_UPDATE = 5'b00010,
        S_LOAD   = 5'b00100,
        S_DIVIDE = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // take the input beat
        logic update;    // retire old sample, store new one, advance position
        logic load;      // start the divider from the running total
        logic step;      // one quotient bit
        logic post;      // load the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic div_last;  // the step under way is the final one
    } t_status;

endpackage
`default_nettype wire

// File: src/rwa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwa_ctrl
// Sequencer for the running window average: accepts a beat, steps the
// datapath through update and serial division, and owns the output valid.
// ----------------------------------------------------------------------------
module rwa_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  wire logic            i_stall,
    input  wire rwa_pkg::t_status i_status,
    output rwa_pkg::t_cmd        o_cmd
);

    rwa_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            w_post;

    // Output register may be loaded when empty or being drained this cycle
    assign w_post = (r_state == rwa_pkg::S_DONE) && (!r_out_valid || !i_stall);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            rwa_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = rwa_pkg::S_UPDATE;
                end
            end
            rwa_pkg::S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = rwa_pkg::S_LOAD;
            end
            rwa_pkg::S_LOAD: begin
                n_state = rwa_pkg::S_DIVIDE;
            end
            rwa_pkg::S_DIVIDE: begin
                o_cmd.step = 1'b1;
                if (i_status.div_last) begin
                    n_state = rwa_pkg::S_DONE;
                end
            end
            rwa_pkg::S_DONE: begin
                if (w_post) begin
                    o_cmd.post = 1'b1;
                    n_state    = rwa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rwa_pkg::S_IDLE;
            end
        endcase
        // Divider start comes in the cycle after the total update
        o_cmd.load = (r_state == rwa_pkg::S_LOAD);
    end

    // Output valid: set on post, drop when the beat is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_post) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rwa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != rwa_pkg::S_IDLE);
    assign o_valid = r_out_valid;

endmodule
`default_nettype wire

// File: src/rwa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwa_datapath
// Sample ring, running total, write position, fill count, serial restoring
// divider and output register of the running window average.
// ----------------------------------------------------------------------------
module rwa_datapath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [rwa_pkg::FILL_BITS-1:0]       i_cfg_data,
    input  wire logic signed [rwa_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire rwa_pkg::t_cmd                       i_cmd,
    output rwa_pkg::t_status                         o_status,
    output logic signed [rwa_pkg::SAMPLE_BITS-1:0]   o_average,
    output logic [rwa_pkg::FILL_BITS-1:0]            o_filled
);

    localparam int SB = rwa_pkg::SAMPLE_BITS;
    localparam int PB = rwa_pkg::POS_BITS;
    localparam int FB = rwa_pkg::FILL_BITS;
    localparam int TB = rwa_pkg::TOTAL_BITS;
    localparam int CB = rwa_pkg::CNT_BITS;

    logic [SB-1:0] r_ring [rwa_pkg::WINDOW_MAX];
    logic [SB-1:0] r_ring_rd;

    logic [FB-1:0] r_len,   n_len;
    logic [PB-1:0] r_pos,   n_pos;
    logic [FB-1:0] r_fill,  n_fill;
    logic [TB-1:0] r_total, n_total;
    logic [SB-1:0] r_sample;

    logic [FB-1:0] r_rem, n_rem;
    logic [TB-1:0] r_quo, n_quo;
    logic [CB-1:0] r_cnt, n_cnt;
    logic          r_neg;

    logic [SB-1:0] r_avg;
    logic [FB-1:0] r_out_fill;

    logic [TB-1:0] w_old;
    logic [TB-1:0] w_new;
    logic [FB-1:0] w_pos_inc;
    logic [FB:0]   w_partial;
    logic [FB:0]   w_diff;
    logic [TB-1:0] w_signed_quo;

    // Ring: one write, one registered read at the write position
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_ring[r_pos] <= r_sample;
        end
        r_ring_rd <= r_ring[r_pos];
    end

    // Hold the accepted sample
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample <= i_sample;
        end
    end

    // Entry at the position holds a live sample only once the window is full
    assign w_old     = (r_fill == r_len) ? {{(TB - SB){r_ring_rd[SB-1]}}, r_ring_rd} : '0;
    assign w_new     = {{(TB - SB){r_sample[SB-1]}}, r_sample};
    assign w_pos_inc = FB'(r_pos) + FB'(1);

    // Window state: restart on a register write, advance on an update
    always_comb begin
        n_len   = r_len;
        n_pos   = r_pos;
        n_fill  = r_fill;
        n_total = r_total;
        priority if (i_cfg_we) begin
            priority if (i_cfg_data == '0) begin
                n_len = FB'(1);
            end else if (i_cfg_data > FB'(rwa_pkg::WINDOW_MAX)) begin
                n_len = FB'(rwa_pkg::WINDOW_MAX);
            end else begin
                n_len = i_cfg_data;
            end
            n_pos   = '0;
            n_fill  = '0;
            n_total = '0;
        end else if (i_cmd.update) begin
            n_total = r_total + w_new - w_old;
            n_pos   = (w_pos_inc >= r_len) ? '0 : w_pos_inc[PB-1:0];
            if (r_fill < r_len) begin
                n_fill = r_fill + FB'(1);
            end
        end else begin
            // Hold
            n_len   = r_len;
            n_pos   = r_pos;
            n_fill  = r_fill;
            n_total = r_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= FB'(rwa_pkg::WINDOW_MAX);
            r_pos   <= '0;
            r_fill  <= '0;
            r_total <= '0;
        end else begin
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_fill  <= n_fill;
            r_total <= n_total;
        end
    end

    // Restoring divider on the magnitude, one quotient bit a cycle
    assign w_partial = {r_rem, r_quo[TB-1]};
    assign w_diff    = w_partial - {1'b0, r_fill};

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        n_cnt = r_cnt;
        priority if (i_cmd.load) begin
            n_rem = '0;
            n_quo = r_total[TB-1] ? (~r_total + TB'(1)) : r_total;
            n_cnt = CB'(TB);
        end else if (i_cmd.step) begin
            if (!w_diff[FB]) begin
                n_rem = w_diff[FB-1:0];
                n_quo = {r_quo[TB-2:0], 1'b1};
            end else begin
                n_rem = w_partial[FB-1:0];
                n_quo = {r_quo[TB-2:0], 1'b0};
            end
            n_cnt = r_cnt - CB'(1);
        end else begin
            // Hold
            n_rem = r_rem;
            n_quo = r_quo;
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_cmd.load) begin
            r_neg <= r_total[TB-1];
        end
    end

    assign o_status.div_last = (r_cnt == CB'(1));

    // Restore the sign, truncated toward zero
    assign w_signed_quo = r_neg ? (~r_quo + TB'(1)) : r_quo;

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.post) begin
            r_avg      <= w_signed_quo[SB-1:0];
            r_out_fill <= r_fill;
        end
    end

    assign o_average = r_avg;
    assign o_filled  = r_out_fill;

endmodule
`default_nettype wire

// File: src/running_window_average.sv
// An accepted beat passes through update, divider load, 22 divider steps, output
// load and output beat before its result beat, and takes longer while output stalls.
// No new beat is taken until the divider is through and the result is posted.
// A new beat is accepted while the previous result waits at the output.
// Reset (synchronous, active low) empties the window, sets the length to 64.
// A length write restarts the window at once and is always ready.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// running_window_average
// Moving average of the most recent samples held in a ring, divided by the
// number of samples present, with a separate length register port.
// ----------------------------------------------------------------------------
module running_window_average (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [rwa_pkg::FILL_BITS-1:0]          i_cfg_data,
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic signed [rwa_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic signed [rwa_pkg::SAMPLE_BITS-1:0]      o_average,
    output logic [rwa_pkg::FILL_BITS-1:0]               o_filled
);

    rwa_pkg::t_cmd    w_cmd;
    rwa_pkg::t_status w_status;
    logic             w_cfg_we;

    // Length writes are always accepted and go straight to the length register
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    rwa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    rwa_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (w_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_sample   (i_sample),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_average  (o_average),
        .o_filled   (o_filled)
    );

endmodule
`default_nettype wire

// File: tb/sv/running_window_average_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_window_average_tb
// Self-checking bench for the moving average block. A queue-fed driver sends
// sample beats in random bursts. A clocked scoreboard keeps its own copy of the
// ring, total, position and fill count. From these it predicts each average
// and checks it against the output beats, which the bench stalls on a pattern
// of its own. The run passes through several window lengths, the clamped ones
// among them.
// ----------------------------------------------------------------------------
module running_window_average_tb;

    localparam int WINDOW_MAX  = rwa_pkg::WINDOW_MAX;
    localparam int SAMPLE_BITS = rwa_pkg::SAMPLE_BITS;
    localparam int FILL_BITS   = rwa_pkg::FILL_BITS;
    localparam int TOTAL_BITS  = rwa_pkg::TOTAL_BITS;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int REPORT_MAX   = 10;

    // Amplitude bias of a random phase
    localparam int BIAS_NONE = 0;
    localparam int BIAS_HIGH = 1;
    localparam int BIAS_LOW  = 2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] average;
        logic [FILL_BITS-1:0]          filled;
    } t_avg_result;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [FILL_BITS-1:0]          i_cfg_data  = '0;
    logic                          i_valid     = 1'b0;
    logic                          o_stall;
    logic signed [SAMPLE_BITS-1:0] i_sample    = '0;
    logic                          o_valid;
    logic                          i_stall     = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_average;
    logic [FILL_BITS-1:0]          o_filled;

    running_window_average dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_average   (o_average),
        .o_filled    (o_filled)
    );

    // Predicted window state
    logic signed [SAMPLE_BITS-1:0] win_ring [WINDOW_MAX];
    logic signed [TOTAL_BITS-1:0]  win_total;
    int                            win_pos;
    int                            win_fill;
    int                            win_len;

    logic [SAMPLE_BITS-1:0] pending_samples [$];
    t_avg_result            avg_expect_q [$];

    logic in_taken  = 1'b0;
    logic cfg_taken = 1'b0;
    int   beats_queued = 0;
    int   beats_in     = 0;
    int   results_seen = 0;
    int   mismatches   = 0;
    int   cfg_writes   = 0;
    int   max_fill     = 0;
    int   cycle_count  = 0;
    int   burst_left   = 1;
    int   gap_left     = 0;
    int   stall_left   = 0;
    int   free_left    = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Window predictor
    // ------------------------------------------------------------------
    function automatic void clear_window();
        foreach (win_ring[k]) win_ring[k] = '0;
        win_total = '0;
        win_pos   = 0;
        win_fill  = 0;
    endfunction

    function automatic void restart_window(input logic [FILL_BITS-1:0] length);
        if (length == 0)
            win_len = 1;
        else if (length > WINDOW_MAX)
            win_len = WINDOW_MAX;
        else
            win_len = int'(length);
        clear_window();
    endfunction

    function automatic t_avg_result advance_window(input logic signed [SAMPLE_BITS-1:0] s);
        t_avg_result r;
        int          slot;
        int          quotient;
        slot = (win_pos >= win_len) ? 0 : win_pos;
        if (win_fill < win_len)
            win_fill++;
        // Retire the overwritten sample, add the new one
        win_total      = win_total + s - win_ring[slot];
        win_ring[slot] = s;
        quotient       = int'(win_total) / win_fill;
        win_pos        = (slot + 1 >= win_len) ? 0 : slot + 1;
        r.average      = quotient[SAMPLE_BITS-1:0];
        r.filled       = win_fill[FILL_BITS-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: check output beats, predict accepted input beats
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : score
        t_avg_result want;
        if (!i_rst_n) begin
            in_taken  <= 1'b0;
            cfg_taken <= 1'b0;
        end else begin
            in_taken  <= i_valid && !o_stall;
            cfg_taken <= i_cfg_valid && o_cfg_ready;

            if (o_valid && !i_stall) begin
                if (avg_expect_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result beat: average %0d filled %0d",
                                 $signed(o_average), o_filled);
                end else begin
                    want = avg_expect_q.pop_front();
                    if (o_average !== want.average || o_filled !== want.filled) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display({"result %0d: average exp %0d got %0d, ",
                                      "filled exp %0d got %0d"},
                                     results_seen, $signed(want.average), $signed(o_average),
                                     want.filled, o_filled);
                    end
                    results_seen++;
                end
            end

            if (i_cfg_valid && o_cfg_ready)
                restart_window(i_cfg_data);

            if (i_valid && !o_stall) begin
                want = advance_window(i_sample);
                avg_expect_q.push_back(want);
                if (win_fill > max_fill)
                    max_fill = win_fill;
                beats_in <= beats_in + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sample driver: bursts of beats with random gaps between them
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : sample_driver
        logic                   nxt_valid;
        logic [SAMPLE_BITS-1:0] nxt_sample;
        int                     r;
        nxt_valid  = i_valid;
        nxt_sample = i_sample;
        if (i_rst_n && (!i_valid || in_taken)) begin
            nxt_valid = 1'b0;
            if (in_taken) begin
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    r = $urandom_range(0, 9);
                    if (r < 4)
                        gap_left = 0;
                    else if (r < 8)
                        gap_left = $urandom_range(1, 30);
                    else
                        gap_left = $urandom_range(31, 90);
                end
            end
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_samples.size() > 0) begin
                nxt_sample = pending_samples.pop_front();
                nxt_valid  = 1'b1;
            end
        end
        i_valid  <= nxt_valid;
        i_sample <= nxt_sample;
    end

    // ------------------------------------------------------------------
    // Result stall pattern
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : result_stall
        logic nxt_stall;
        nxt_stall = 1'b0;
        if (stall_left > 0) begin
            stall_left--;
            nxt_stall = 1'b1;
        end else if (free_left > 0) begin
            free_left--;
        end else begin
            case ($urandom_range(0, 3))
                0: free_left = $urandom_range(50, 300);
                1: begin
                    stall_left = $urandom_range(1, 3);
                    free_left  = $urandom_range(1, 3);
                end
                2: begin
                    stall_left = $urandom_range(20, 60);
                    free_left  = $urandom_range(1, 10);
                end
                default: begin
                    stall_left = $urandom_range(1, 25);
                    free_left  = $urandom_range(1, 40);
                end
            endcase
        end
        i_stall <= nxt_stall;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequencing
    // ------------------------------------------------------------------
    task automatic queue_sample(input logic [SAMPLE_BITS-1:0] s);
        pending_samples.push_back(s);
        beats_queued++;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int bias);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (bias == BIAS_HIGH && r < 70) begin
            v = $urandom_range(32000, 32767);
        end else if (bias == BIAS_LOW && r < 70) begin
            v = -int'($urandom_range(32000, 32768));
        end else if (r < 10) begin
            v = 32767;
        end else if (r < 20) begin
            v = -32768;
        end else if (r < 35) begin
            v = int'($urandom_range(0, 16)) - 8;
        end else begin
            v = $urandom_range(0, 65535);
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    task automatic queue_random(input int n, input int bias);
        repeat (n) queue_sample(pick_sample(bias));
    endtask

    // Hold until every queued beat has been accepted and answered
    task automatic wait_idle();
        while (!(pending_samples.size() == 0 && beats_in == beats_queued &&
                 avg_expect_q.size() == 0))
            @(negedge i_clk);
    endtask

    task automatic write_length(input logic [FILL_BITS-1:0] length);
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = length;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid = 1'b0;
        cfg_writes++;
    endtask

    initial begin : sequencer
        int leftover;
        win_len = WINDOW_MAX;
        clear_window();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset length: field extremes and alternating bit patterns, then fill and wrap
        queue_sample(16'h7FFF);
        queue_sample(16'h8000);
        queue_sample(16'h0000);
        queue_sample(16'hFFFF);
        queue_sample(16'h0001);
        queue_sample(16'h5555);
        queue_sample(16'hAAAA);
        queue_sample(16'h7FFF);
        queue_sample(16'h7FFF);
        queue_sample(16'h8000);
        queue_sample(16'h8000);
        queue_sample(16'h0000);
        queue_random(150, BIAS_NONE);

        // Length zero acts as a single-sample window
        write_length(7'd0);
        queue_sample(16'h7FFF);
        queue_sample(16'h8000);
        queue_sample(16'hFFFF);
        queue_sample(16'h0001);
        queue_sample(16'h0000);
        queue_random(60, BIAS_NONE);

        write_length(7'd1);
        queue_random(80, BIAS_NONE);
        write_length(7'd2);
        queue_random(100, BIAS_LOW);
        // Full window at full scale stresses the total width
        write_length(7'd64);
        queue_random(200, BIAS_HIGH);
        // Rewriting the same length restarts the window
        write_length(7'd64);
        queue_random(100, BIAS_LOW);
        // Lengths above the maximum saturate
        write_length(7'd127);
        queue_random(150, BIAS_NONE);
        write_length(7'd65);
        queue_random(50, BIAS_HIGH);
        write_length(7'd63);
        queue_random(150, BIAS_NONE);

        repeat (6) begin
            write_length(FILL_BITS'($urandom_range(1, 64)));
            queue_random(70, int'($urandom_range(BIAS_NONE, BIAS_LOW)));
        end

        // Drain and settle
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        leftover = avg_expect_q.size();
        if (leftover > 0) begin
            mismatches += leftover;
            $display("%0d expected results never arrived", leftover);
        end

        $display("Sent %0d samples over %0d length writes; %0d averages checked, peak fill %0d.",
                 beats_in, cfg_writes, results_seen, max_fill);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
